// ===== hdl/hrlc_pkg.sv =====
// Shared types, constants and character tables for the request line checker.
package hrlc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned URI_W       = 10;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned FC_W        = 4;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Longest method accepted before the line is a bad request.
  localparam logic [FC_W-1:0] METHOD_LIMIT = FC_W'(7);

  localparam logic [URI_W-1:0] MAX_URI_RESET = URI_W'(200);

  // Register index as decoded from the word address.
  localparam logic REG_MAX_URI = 1'b0;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_METHOD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_URI_LONG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_VERSION  = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              line_start;
  } line_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_post;
    logic [URI_W-1:0]    uri_length;
  } line_out_t;

  // One byte after classification by the front end.
  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              start;
    logic              is_space;
    logic              is_cr;
    logic              is_zero;
    logic              is_one;
  } byte_cls_t;

  // Queue status, seen by both the front end and the parser.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic [BYTE_W-1:0] get_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      2'd0:    c = 8'h47;  // G
      2'd1:    c = 8'h45;  // E
      default: c = 8'h54;  // T
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] post_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      2'd0:    c = 8'h50;  // P
      2'd1:    c = 8'h4F;  // O
      2'd2:    c = 8'h53;  // S
      default: c = 8'h54;  // T
    endcase
    return c;
  endfunction

  // The first seven characters of the version string; the last one is checked apart.
  function automatic logic [BYTE_W-1:0] ver_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      3'd4:    c = 8'h2F;  // /
      3'd5:    c = 8'h31;  // 1
      default: c = 8'h2E;  // .
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hrlc_front.sv =====
// Input side: accepts request line bytes and classifies them for the parser.
module hrlc_front import hrlc_pkg::*; (
  input  line_in_t      in_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  queue_status_t q_status,
  output logic          push,
  output byte_cls_t     push_data
);

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_data.line_byte = in_data.line_byte;
    push_data.start     = in_data.line_start;
    push_data.is_space  = (in_data.line_byte == CHAR_SPACE);
    push_data.is_cr     = (in_data.line_byte == CHAR_CR);
    push_data.is_zero   = (in_data.line_byte == CHAR_ZERO);
    push_data.is_one    = (in_data.line_byte == CHAR_ONE);
  end

endmodule

// ===== hdl/hrlc_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
module hrlc_queue import hrlc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  byte_cls_t     push_data,
  input  logic          pop,
  output byte_cls_t     head,
  output queue_status_t q_status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  byte_cls_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.valid = (count_r != '0);
  assign head           = mem_r[rd_ptr_r];

  assign do_push = push && !q_status.full;
  assign do_pop  = pop && q_status.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

endmodule

// ===== hdl/hrlc_back.sv =====
// Parser: walks method, URI and version phases and registers one result per line.
module hrlc_back import hrlc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  byte_cls_t        item,
  input  queue_status_t    q_status,
  output logic             pop,
  input  logic [URI_W-1:0] max_uri_length,
  output line_out_t        out_data,
  output logic             out_valid,
  input  logic             out_stall
);

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_URI,
    PH_VERSION
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic [URI_W-1:0] uri_r, uri_nxt;
  logic             get_r, get_nxt;
  logic             post_r, post_nxt;
  logic [1:0]       ver_r, ver_nxt;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;
  line_out_t        out_data_r, out_data_nxt;

  phase_t           c_phase;
  logic [FC_W-1:0]  c_fc;
  logic [URI_W-1:0] c_uri;
  logic             c_get, c_post, c_fin, c_is_post;
  logic [1:0]       c_ver, v_ver;
  logic             emit;
  line_out_t        res;
  logic             g_ok, p_ok;

  // A new byte is taken only when the output register can hold a possible result.
  assign pop = q_status.valid && (!out_valid_r || !out_stall);

  always_comb begin
    // The start flag clears the line before this byte is parsed.
    c_phase   = item.start ? PH_METHOD : phase_r;
    c_fc      = item.start ? '0 : fc_r;
    c_uri     = item.start ? '0 : uri_r;
    c_get     = item.start ? 1'b1 : get_r;
    c_post    = item.start ? 1'b1 : post_r;
    c_ver     = item.start ? 2'b11 : ver_r;
    c_fin     = item.start ? 1'b0 : fin_r;
    c_is_post = !c_get && c_post;

    phase_nxt = c_phase;
    fc_nxt    = c_fc;
    uri_nxt   = c_uri;
    get_nxt   = c_get;
    post_nxt  = c_post;
    ver_nxt   = c_ver;
    fin_nxt   = c_fin;
    emit      = 1'b0;
    res       = '{status: ST_OK, is_post: c_is_post, uri_length: c_uri};
    g_ok      = c_get && (c_fc == FC_W'(3));
    p_ok      = c_post && (c_fc == FC_W'(4));
    v_ver     = c_ver;

    if (!c_fin) begin
      unique case (c_phase)
        PH_METHOD: begin
          if (item.is_space) begin
            if (!g_ok && !p_ok) begin
              emit = 1'b1;
              res  = '{status: ST_METHOD, is_post: 1'b0, uri_length: '0};
            end else begin
              get_nxt   = g_ok;
              post_nxt  = p_ok;
              phase_nxt = PH_URI;
              fc_nxt    = '0;
            end
          end else if (c_fc >= METHOD_LIMIT) begin
            emit = 1'b1;
            res  = '{status: ST_BAD, is_post: 1'b0, uri_length: '0};
          end else begin
            if (c_fc >= FC_W'(3) || get_char(c_fc[1:0]) != item.line_byte) begin
              get_nxt = 1'b0;
            end
            if (c_fc >= FC_W'(4) || post_char(c_fc[1:0]) != item.line_byte) begin
              post_nxt = 1'b0;
            end
            fc_nxt = c_fc + FC_W'(1);
          end
        end
        PH_URI: begin
          if (item.is_space) begin
            phase_nxt = PH_VERSION;
            fc_nxt    = '0;
          end else if (c_uri >= max_uri_length) begin
            emit       = 1'b1;
            res.status = ST_URI_LONG;
          end else begin
            uri_nxt = c_uri + URI_W'(1);
          end
        end
        PH_VERSION: begin
          if (item.is_cr) begin
            emit       = 1'b1;
            res.status = (c_fc == FC_W'(8) && c_ver != 2'b00) ? ST_OK : ST_VERSION;
          end else if (c_fc >= FC_W'(8)) begin
            emit       = 1'b1;
            res.status = ST_VERSION;
          end else begin
            // The last character picks between the two accepted minor versions.
            if (c_fc == FC_W'(7)) begin
              if (!item.is_zero) begin
                v_ver[0] = 1'b0;
              end
              if (!item.is_one) begin
                v_ver[1] = 1'b0;
              end
            end else if (ver_char(c_fc[2:0]) != item.line_byte) begin
              v_ver = 2'b00;
            end
            ver_nxt = v_ver;
            fc_nxt  = c_fc + FC_W'(1);
            if (v_ver == 2'b00) begin
              emit       = 1'b1;
              res.status = ST_VERSION;
            end
          end
        end
        default: begin
          phase_nxt = c_phase;
        end
      endcase
    end

    if (emit) begin
      fin_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      fc_r        <= '0;
      uri_r       <= '0;
      get_r       <= 1'b1;
      post_r      <= 1'b1;
      ver_r       <= 2'b11;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        fc_r    <= fc_nxt;
        uri_r   <= uri_nxt;
        get_r   <= get_nxt;
        post_r  <= post_nxt;
        ver_r   <= ver_nxt;
        fin_r   <= fin_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit) |=> (fin_r && out_valid_r))
    else $error("result issued without closing the line");

  a_method_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_METHOD) |-> (fc_r <= METHOD_LIMIT))
    else $error("method count past limit");

  a_version_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VERSION) |-> (fc_r <= FC_W'(8)))
    else $error("version count past eight");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !pop)
    else $error("byte parsed while result is held");

endmodule

// ===== hdl/http_request_line_checker.sv =====
// The block takes one request line byte per cycle with no bubbles while its queue is not full
// and returns at most one result per line: the status, the POST flag and the URI length, given
// at the first error or at CR. Each byte is classified on entry and goes into a DEPTH-entry
// queue (four by default); the parser takes one byte a cycle from its head unless the output
// stalls, and each result is held in an output register. A stalled output holds the parser,
// and in_stall rises only once the queue is full. Bytes after a result are dropped until a
// byte with line_start set. The URI limit is a 10-bit register at byte address 0 (reset 200).
module http_request_line_checker import hrlc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  line_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output line_out_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [URI_W-1:0] max_uri_r, max_uri_nxt;
  logic             cfg_wr;
  logic             push, pop;
  byte_cls_t        push_data, head;
  queue_status_t    q_status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_URI) ?
                      {{(CFG_DATA_W - URI_W){1'b0}}, max_uri_r} : '0;

  always_comb begin
    max_uri_nxt = max_uri_r;
    if (cfg_wr && cfg_paddr[2] == REG_MAX_URI) begin
      max_uri_nxt = cfg_pwdata[URI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_uri_r <= MAX_URI_RESET;
    end else begin
      max_uri_r <= max_uri_nxt;
    end
  end

  hrlc_front u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  hrlc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  hrlc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (head),
    .q_status       (q_status),
    .pop            (pop),
    .max_uri_length (max_uri_r),
    .out_data       (out_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule
